// ----- rtl/pfcr_pkg.sv -----
// pfcr_pkg: shared types, constants and flag helpers of the clock page replacer
// used by page_fault_clock_replacer_unit
`timescale 1ns / 1ps
`default_nettype none

package pfcr_pkg;

    localparam int VPAGES = 256;
    localparam int FRAMES = 64;
    localparam int BLOCKS = 256;

    localparam int VP_W  = $clog2(VPAGES);
    localparam int FR_W  = $clog2(FRAMES);
    localparam int BLK_W = $clog2(BLOCKS);
    localparam int FLG_W = 7;

    // flag bit positions
    localparam int FL_REF    = 0;
    localparam int FL_RES    = 1;
    localparam int FL_DIRTY  = 2;
    localparam int FL_ZERO   = 3;
    localparam int FL_RD     = 4;
    localparam int FL_WR     = 5;
    localparam int FL_SAVEDW = 6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_ZERO = 2'd1;
    localparam logic [1:0] FILL_DISK = 2'd2;

    localparam logic OP_EXTEND = 1'b0;
    localparam logic OP_FAULT  = 1'b1;

    localparam logic [1:0] CFG_MEM_PAGES  = 2'd0;
    localparam logic [1:0] CFG_DISK_BLKS  = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RING,
        S_VICT,
        S_FIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [FLG_W-1:0] flags;
        logic [FR_W-1:0]  frame;
        logic [BLK_W-1:0] block;
    } t_pte;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       alloc;
        logic [5:0]       frame;
        logic [1:0]       fact;
        logic [7:0]       fblk;
        logic             wb;
        logic [7:0]       wblk;
        logic             re;
        logic             we;
    } t_res;

    // a write access grants write, makes the page dirty and no longer zero-fill
    function automatic logic [FLG_W-1:0] apply_wr(input logic [FLG_W-1:0] f, input logic wr);
        logic [FLG_W-1:0] r;
        r = f;
        if (wr) begin
            r[FL_WR]     = 1'b1;
            r[FL_RD]     = 1'b1;
            r[FL_SAVEDW] = 1'b1;
            r[FL_DIRTY]  = 1'b1;
            r[FL_REF]    = 1'b1;
            r[FL_RES]    = 1'b1;
            r[FL_ZERO]   = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pfcr_ram.sv -----
// pfcr_ram: simple dual-port synchronous ram, registered read
// write data is forwarded when read and write hit the same entry; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pfcr_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            o_rdata <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/page_fault_clock_replacer_unit.sv -----
// page_fault_clock_replacer_unit: top level, control sequencer and counters
// uses pfcr_pkg and two pfcr_ram instances (page table, clock ring)
// ----------------------------------------------------------------------------
// Pager for one address space with clock (second chance) replacement.
// Input stream: tuser[0] = operation (0 extend, 1 fault), tdata holds the
// page number and the write flag. One result word comes out per input word
// on the master stream; tuser carries the status.
// Config channel: index 0 loads the frame count (bits [6:0], clamped to 64),
// index 1 the disk block count (clamped to 256). It is ready only while the
// block is idle, and a pending config write holds off the input stream.
// Extend and invalid-page faults go from idle straight to the emit state; a
// fault on a mapped page passes through the lookup state, one that takes a
// free frame through lookup and finish. A fault that needs eviction walks
// the clock ring: per ring entry visited, a ring read, then a page table
// read of that entry, at most 2*N+1 entries with N resident pages. One word
// is worked on at a time. Reset sets the free frame and block counts to 64
// and 256 and clears the page count and the ring pointers; the page table
// and ring contents need no clearing. When the receiver stalls, the finished
// result waits in the output register while the next word is taken and
// processed; that word's result then waits until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module page_fault_clock_replacer_unit
    import pfcr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // vpage_index[7:0], write_access[8]
    input  wire logic [0:0]  i_s_tuser,   // operation[0]
    // output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // allocated_vpage[7:0], phys_frame[13:8], fill_action[15:14], fill_block[23:16],
    // writeback[24], writeback_block[32:25], read permission[33], write permission[34]
    output logic      [39:0] o_m_tdata,
    output logic      [1:0]  o_m_tuser    // status[1:0]
);

    t_state r_state, n_state;

    logic             r_wr, n_wr;
    logic [VP_W-1:0]  r_vp, n_vp;
    t_pte             r_vent, n_vent;
    logic [VP_W-1:0]  r_victim, n_victim;
    logic [7:0]       r_cnt, n_cnt;
    logic [7:0]       r_guard, n_guard;
    logic [FR_W-1:0]  r_fr, n_fr;
    logic             r_wb, n_wb;
    logic [BLK_W-1:0] r_wblk, n_wblk;
    t_res             r_res, n_res;
    t_res             r_out, n_out;
    logic             r_ovalid, n_ovalid;

    logic [6:0]       r_ffc, n_ffc;
    logic [8:0]       r_fbc, n_fbc;
    logic [FR_W-1:0]  r_head, n_head;
    logic [6:0]       r_fill, n_fill;
    logic [8:0]       r_vc, n_vc;

    // memory ports
    logic             pg_we;
    logic [VP_W-1:0]  pg_waddr, pg_raddr;
    t_pte             pg_wdata, pg_q;
    logic             rg_we;
    logic [FR_W-1:0]  rg_waddr, rg_raddr;
    logic [VP_W-1:0]  rg_wdata, rg_q;

    logic             accept;
    logic             out_free;
    logic             need_evict;
    logic             rotate;
    logic [FR_W-1:0]  tail;

    pfcr_ram #(.DEPTH(VPAGES), .WIDTH($bits(t_pte))) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_raddr (pg_raddr),
        .o_rdata (pg_q)
    );

    pfcr_ram #(.DEPTH(FRAMES), .WIDTH(VP_W)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (rg_we),
        .i_waddr (rg_waddr),
        .i_wdata (rg_wdata),
        .i_raddr (rg_raddr),
        .o_rdata (rg_q)
    );

    // a config write takes the idle slot ahead of an input word
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;
    assign out_free    = !r_ovalid || i_m_tready;
    assign need_evict  = (r_ffc == 7'd0) || r_fill[6];
    assign rotate      = pg_q.flags[FL_REF] && ((r_cnt + 8'd1) < r_guard);
    assign tail        = r_head + r_fill[FR_W-1:0];

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {5'd0, r_out.we, r_out.re, r_out.wblk, r_out.wb, r_out.fblk,
                         r_out.fact, r_out.frame, r_out.alloc};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_tuser[0] == OP_EXTEND || {1'b0, i_s_tdata[7:0]} >= r_vc) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (pg_q.flags[FL_RD] || pg_q.flags[FL_RES]) begin
                    n_state = S_EMIT;
                end else if (need_evict && r_fill == 7'd0) begin
                    n_state = S_EMIT;
                end else if (need_evict) begin
                    n_state = S_RING;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RING:  n_state = S_VICT;
            S_VICT:  n_state = rotate ? S_RING : S_FIN;
            S_FIN:   n_state = S_EMIT;
            S_EMIT:  n_state = out_free ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        logic [FLG_W-1:0] f;
        logic [8:0]       fbc_dec;
        logic [6:0]       ffc_dec;

        n_wr     = r_wr;
        n_vp     = r_vp;
        n_vent   = r_vent;
        n_victim = r_victim;
        n_cnt    = r_cnt;
        n_guard  = r_guard;
        n_fr     = r_fr;
        n_wb     = r_wb;
        n_wblk   = r_wblk;
        n_res    = r_res;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        n_ffc    = r_ffc;
        n_fbc    = r_fbc;
        n_head   = r_head;
        n_fill   = r_fill;
        n_vc     = r_vc;

        pg_we    = 1'b0;
        pg_waddr = r_vp;
        pg_wdata = '0;
        pg_raddr = r_vp;
        rg_we    = 1'b0;
        rg_waddr = tail;
        rg_wdata = r_vp;
        rg_raddr = r_head;

        f       = '0;
        fbc_dec = r_fbc - 9'd1;
        ffc_dec = r_ffc - 7'd1;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    if (i_cfg_index == CFG_MEM_PAGES) begin
                        n_ffc = (i_cfg_data[6:0] > 7'(FRAMES)) ? 7'(FRAMES) : i_cfg_data[6:0];
                    end else if (i_cfg_index == CFG_DISK_BLKS) begin
                        n_fbc = (i_cfg_data > 9'(BLOCKS)) ? 9'(BLOCKS) : i_cfg_data;
                    end
                end
                if (accept) begin
                    n_vp     = i_s_tdata[7:0];
                    n_wr     = i_s_tdata[8];
                    n_res    = '0;
                    pg_raddr = i_s_tdata[7:0];
                    if (i_s_tuser[0] == OP_EXTEND) begin
                        if (r_fbc == 9'd0 || r_vc[8]) begin
                            n_res.status = ST_FULL;
                        end else begin
                            n_fbc          = fbc_dec;
                            n_vc           = r_vc + 9'd1;
                            pg_we          = 1'b1;
                            pg_waddr       = r_vc[7:0];
                            pg_wdata.block = fbc_dec[7:0];
                            pg_wdata.frame = '0;
                            pg_wdata.flags = FLG_W'(1) << FL_ZERO;
                            n_res.alloc    = r_vc[7:0];
                        end
                    end else if ({1'b0, i_s_tdata[7:0]} >= r_vc) begin
                        n_res.status = ST_INVALID;
                    end
                end
            end
            S_LOOK: begin
                n_vent = pg_q;
                f      = pg_q.flags;
                if (f[FL_RD] || f[FL_RES]) begin
                    if (!f[FL_RD]) begin
                        // resident but revoked by the sweep: second chance
                        f[FL_REF] = 1'b1;
                        f[FL_RD]  = 1'b1;
                        f[FL_WR]  = f[FL_SAVEDW];
                    end
                    f              = apply_wr(f, r_wr);
                    pg_we          = 1'b1;
                    pg_wdata       = pg_q;
                    pg_wdata.flags = f;
                    n_res.frame    = pg_q.frame;
                    n_res.re       = f[FL_RD];
                    n_res.we       = f[FL_WR];
                end else if (need_evict && r_fill == 7'd0) begin
                    n_res.status = ST_FULL;
                end else if (need_evict) begin
                    rg_raddr = r_head;
                    n_guard  = {r_fill, 1'b1};
                    n_cnt    = '0;
                end else begin
                    n_ffc  = ffc_dec;
                    n_fr   = ffc_dec[FR_W-1:0];
                    n_wb   = 1'b0;
                    n_wblk = '0;
                end
            end
            S_RING: begin
                n_victim = rg_q;
                pg_raddr = rg_q;
            end
            S_VICT: begin
                pg_we    = 1'b1;
                pg_waddr = r_victim;
                pg_wdata = pg_q;
                if (rotate) begin
                    pg_wdata.flags[FL_REF] = 1'b0;
                    pg_wdata.flags[FL_RD]  = 1'b0;
                    pg_wdata.flags[FL_WR]  = 1'b0;
                    // pop the head and push it at the tail
                    rg_we    = 1'b1;
                    rg_waddr = tail;
                    rg_wdata = r_victim;
                    n_head   = r_head + FR_W'(1);
                    rg_raddr = r_head + FR_W'(1);
                    n_cnt    = r_cnt + 8'd1;
                end else begin
                    pg_wdata.flags[FL_RES]    = 1'b0;
                    pg_wdata.flags[FL_DIRTY]  = 1'b0;
                    pg_wdata.flags[FL_RD]     = 1'b0;
                    pg_wdata.flags[FL_WR]     = 1'b0;
                    pg_wdata.flags[FL_SAVEDW] = 1'b0;
                    n_head = r_head + FR_W'(1);
                    n_fill = r_fill - 7'd1;
                    n_fr   = pg_q.frame;
                    n_wb   = pg_q.flags[FL_DIRTY];
                    n_wblk = pg_q.flags[FL_DIRTY] ? pg_q.block : '0;
                end
            end
            S_FIN: begin
                f = r_vent.flags;
                if (f[FL_ZERO]) begin
                    n_res.fact = FILL_ZERO;
                    n_res.fblk = '0;
                end else begin
                    n_res.fact = FILL_DISK;
                    n_res.fblk = r_vent.block;
                end
                f[FL_RD]    = 1'b1;
                f[FL_REF]   = 1'b1;
                f[FL_RES]   = 1'b1;
                f[FL_DIRTY] = 1'b0;
                f           = apply_wr(f, r_wr);
                pg_we          = 1'b1;
                pg_waddr       = r_vp;
                pg_wdata.block = r_vent.block;
                pg_wdata.frame = r_fr;
                pg_wdata.flags = f;
                rg_we    = 1'b1;
                rg_waddr = tail;
                rg_wdata = r_vp;
                n_fill   = r_fill + 7'd1;
                n_res.frame = r_fr;
                n_res.wb    = r_wb;
                n_res.wblk  = r_wblk;
                n_res.re    = f[FL_RD];
                n_res.we    = f[FL_WR];
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ffc    <= 7'(FRAMES);
            r_fbc    <= 9'(BLOCKS);
            r_head   <= '0;
            r_fill   <= '0;
            r_vc     <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_ffc    <= n_ffc;
            r_fbc    <= n_fbc;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_vc     <= n_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr     <= n_wr;
        r_vp     <= n_vp;
        r_vent   <= n_vent;
        r_victim <= n_victim;
        r_cnt    <= n_cnt;
        r_guard  <= n_guard;
        r_fr     <= n_fr;
        r_wb     <= n_wb;
        r_wblk   <= n_wblk;
        r_res    <= n_res;
        r_out    <= n_out;
    end

endmodule

`default_nettype wire
